>>> sv/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the depth-first topological sorter.
// ----------------------------------------------------------------------------
package dts_pkg;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_COUNT  = 2'd1,
		ST_BAD_VERTEX = 2'd2,
		ST_CYCLE      = 2'd3
	} status_t;

	localparam logic [1:0] COL_WHITE = 2'd0;
	localparam logic [1:0] COL_GREY  = 2'd1;
	localparam logic [1:0] COL_BLACK = 2'd2;

	typedef struct packed {
		logic [9:0] edge_from;
		logic [9:0] edge_to;
		logic       edge_valid;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [6:0] vertex;
		status_t    status;
		logic       last_result;
	} out_word_t;

	typedef struct packed {
		logic    in_ready;
		logic    clr_color;
		logic    clr_graph;
		logic    walk_init;
		logic    r_inc;
		logic    color_rd_root;
		logic    start_root;
		logic    edge_rd;
		logic    e_inc;
		logic    color_rd_tgt;
		logic    push;
		logic    finish;
		logic    stack_rd;
		logic    pop_load;
		logic    ptr_init;
		logic    ptr_dec;
		logic    fin_rd;
		logic    out_load;
		logic    out_vertex;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic cnt_err;
		logic vtx_err;
		logic root_done;
		logic root_white;
		logic edge_end;
		logic src_match;
		logic tgt_out;
		logic tgt_grey;
		logic tgt_white;
		logic stack_full;
		logic sp_one;
		logic fc_zero;
		logic ptr_zero;
		logic out_taken;
	} sts_t;

endpackage

>>> sv/dts_if.sv
// ----------------------------------------------------------------------------
// dts_if
// Valid/ready channels of the sorter: edge input, result output, config.
// ----------------------------------------------------------------------------
interface dts_in_if;
	import dts_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dts_out_if;
	import dts_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dts_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> sv/dfs_topological_sort.sv
// ----------------------------------------------------------------------------
// dfs_topological_sort
// Topological sort of a directed graph by depth-first search.
// ----------------------------------------------------------------------------
// Edges are taken one word per cycle and stored in arrival order; the word
// marked last starts the sort and no further input is taken until the run's
// final result word has been delivered. The walk is run by one sequencer over
// single-port edge memory, reading the stored edges one at a time for the
// vertex on top of its stack; the result words are then emitted one by one.
// Errors (edge count above n(n+1)/2 or MAX_EDGES, vertex out of range,
// cycle) give a single status word with vertex 0.
module dfs_topological_sort #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 4096
) (
	input logic       clk,
	input logic       arst_n,
	dts_cfg_if.sink   cfg,
	dts_in_if.sink    edge_in,
	dts_out_if.source result_out
);
	import dts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready     = 1'b1;
	assign edge_in.ready = cmd.in_ready;

	dts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (edge_in.valid),
		.in_last  (edge_in.data.last),
		.sts      (sts),
		.cmd      (cmd)
	);

	dts_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.in_valid  (edge_in.valid),
		.in_data   (edge_in.data),
		.out_ready (result_out.ready),
		.out_valid (result_out.valid),
		.out_data  (result_out.data),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> !edge_in.ready)
		else $error("input open while a result word is pending");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(edge_in.valid && edge_in.ready && edge_in.data.last) |=> !edge_in.ready)
		else $error("input still open after last word");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.data.status != ST_OK) |->
		(result_out.data.vertex == 7'd0 && result_out.data.last_result))
		else $error("error word malformed");

endmodule

>>> sv/dts_ctrl.sv
// ----------------------------------------------------------------------------
// dts_ctrl
// Sequencer of the sorter: load, checks, depth-first walk, result emission.
// ----------------------------------------------------------------------------
module dts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	input  dts_pkg::sts_t sts,
	output dts_pkg::cmd_t cmd
);
	import dts_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_CHECK     = 13'b0000000000010,
		S_ROOT      = 13'b0000000000100,
		S_ROOT_CHK  = 13'b0000000001000,
		S_SCAN      = 13'b0000000010000,
		S_SCAN_CHK  = 13'b0000000100000,
		S_TGT_CHK   = 13'b0000001000000,
		S_FINISH    = 13'b0000010000000,
		S_POP       = 13'b0000100000000,
		S_EMIT_RD   = 13'b0001000000000,
		S_EMIT_LD   = 13'b0010000000000,
		S_EMIT_WAIT = 13'b0100000000000,
		S_STAT_WAIT = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.out_status = ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid && in_last) state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.clr_color = 1'b1;
				if (sts.cnt_err) begin
					cmd.clr_graph = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_status = ST_BAD_COUNT;
					state_d = S_STAT_WAIT;
				end else if (sts.vtx_err) begin
					cmd.clr_graph = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_status = ST_BAD_VERTEX;
					state_d = S_STAT_WAIT;
				end else begin
					cmd.walk_init = 1'b1;
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				if (sts.root_done) begin
					cmd.clr_graph = 1'b1;
					if (sts.fc_zero) begin
						// empty graph: one plain closing word
						cmd.out_load = 1'b1;
						state_d = S_STAT_WAIT;
					end else begin
						cmd.ptr_init = 1'b1;
						state_d = S_EMIT_RD;
					end
				end else begin
					cmd.color_rd_root = 1'b1;
					state_d = S_ROOT_CHK;
				end
			end
			S_ROOT_CHK: begin
				if (sts.root_white) begin
					cmd.start_root = 1'b1;
					state_d = S_SCAN;
				end else begin
					cmd.r_inc = 1'b1;
					state_d = S_ROOT;
				end
			end
			S_SCAN: begin
				if (sts.edge_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				cmd.e_inc = 1'b1;
				if (sts.src_match && !sts.tgt_out) begin
					cmd.color_rd_tgt = 1'b1;
					state_d = S_TGT_CHK;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_TGT_CHK: begin
				if (sts.tgt_grey) begin
					cmd.clr_graph = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_status = ST_CYCLE;
					state_d = S_STAT_WAIT;
				end else begin
					cmd.push = sts.tgt_white && !sts.stack_full;
					state_d = S_SCAN;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				if (sts.sp_one) begin
					cmd.r_inc = 1'b1;
					state_d = S_ROOT;
				end else begin
					cmd.stack_rd = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.pop_load = 1'b1;
				state_d = S_SCAN;
			end
			S_EMIT_RD: begin
				cmd.fin_rd = 1'b1;
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_vertex = 1'b1;
				state_d = S_EMIT_WAIT;
			end
			S_EMIT_WAIT: begin
				if (sts.out_taken) begin
					if (sts.ptr_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.ptr_dec = 1'b1;
						state_d = S_EMIT_RD;
					end
				end
			end
			S_STAT_WAIT: begin
				if (sts.out_taken) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> sv/dts_dp.sv
// ----------------------------------------------------------------------------
// dts_dp
// Datapath of the sorter: edge, colour, stack and finish memories, counters
// and the output word register.
// ----------------------------------------------------------------------------
module dts_dp #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_data,
	input  logic              in_valid,
	input  dts_pkg::in_word_t in_data,
	input  logic              out_ready,
	output logic              out_valid,
	output dts_pkg::out_word_t out_data,
	input  dts_pkg::cmd_t     cmd,
	output dts_pkg::sts_t     sts
);
	import dts_pkg::*;

	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int SW = $clog2(MAX_VERTICES + 1);
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 2);

	logic [6:0]    n_q;
	logic [CW-1:0] edge_count_q;
	logic          bad_q;

	logic [VW-1:0] edge_src_mem [MAX_EDGES];
	logic [VW-1:0] edge_dst_mem [MAX_EDGES];
	logic [VW-1:0] src_rd_q, dst_rd_q;

	logic [1:0]              col_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] col_valid_q;
	logic [1:0]              col_rd_q;

	logic [VW+CW-1:0] stack_mem [MAX_VERTICES];
	logic [VW+CW-1:0] stack_rd_q;
	logic [VW-1:0]    fin_mem [MAX_VERTICES];
	logic [VW-1:0]    fin_rd_q;

	logic [SW-1:0] r_q, sp_q, fc_q;
	logic [VW-1:0] cur_v_q, ptr_q;
	logic [CW-1:0] cur_e_q;

	logic          in_acc, bad_in;
	logic [13:0]   limit;
	logic [VW-1:0] col_rd_addr, col_wr_addr;
	logic [1:0]    col_wr_data;
	logic          col_we;

	assign in_acc = in_valid && cmd.in_ready;
	assign bad_in = (in_data.edge_from == 10'd0) || (in_data.edge_to == 10'd0) ||
		(32'(in_data.edge_from) > 32'(n_q)) || (32'(in_data.edge_to) > 32'(n_q)) ||
		(32'(in_data.edge_from) > MAX_VERTICES) || (32'(in_data.edge_to) > MAX_VERTICES);

	// n(n+1)/2 on a 7-bit n
	assign limit = 14'((14'(n_q) * (14'(n_q) + 14'd1)) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cfg_we) begin
			n_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			bad_q        <= 1'b0;
		end else if (cmd.clr_graph) begin
			edge_count_q <= '0;
			bad_q        <= 1'b0;
		end else if (in_acc && in_data.edge_valid) begin
			if (bad_in) bad_q <= 1'b1;
			if (32'(edge_count_q) <= MAX_EDGES) edge_count_q <= edge_count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.edge_valid && !bad_in && 32'(edge_count_q) < MAX_EDGES) begin
			edge_src_mem[edge_count_q[EW-1:0]] <= VW'(in_data.edge_from - 10'd1);
			edge_dst_mem[edge_count_q[EW-1:0]] <= VW'(in_data.edge_to - 10'd1);
		end
		if (cmd.edge_rd) begin
			src_rd_q <= edge_src_mem[cur_e_q[EW-1:0]];
			dst_rd_q <= edge_dst_mem[cur_e_q[EW-1:0]];
		end
	end

	// colour memory, one write and one read a cycle
	assign col_rd_addr = cmd.color_rd_root ? VW'(r_q) : dst_rd_q;
	always_comb begin
		col_we      = 1'b1;
		col_wr_addr = cur_v_q;
		col_wr_data = COL_BLACK;
		priority if (cmd.start_root) begin
			col_wr_addr = VW'(r_q);
			col_wr_data = COL_GREY;
		end else if (cmd.push) begin
			col_wr_addr = dst_rd_q;
			col_wr_data = COL_GREY;
		end else if (cmd.finish) begin
			col_wr_addr = cur_v_q;
		end else begin
			col_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) col_mem[col_wr_addr] <= col_wr_data;
		if (cmd.color_rd_root || cmd.color_rd_tgt) begin
			col_rd_q <= col_valid_q[col_rd_addr] ? col_mem[col_rd_addr] : COL_WHITE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_valid_q <= '0;
		end else if (cmd.clr_color) begin
			col_valid_q <= '0;
		end else if (col_we) begin
			col_valid_q[col_wr_addr] <= 1'b1;
		end
	end

	// stack and finish memories
	always_ff @(posedge clk) begin
		if (cmd.push) stack_mem[VW'(sp_q - SW'(1))] <= {cur_v_q, cur_e_q};
		if (cmd.stack_rd) stack_rd_q <= stack_mem[VW'(sp_q - SW'(2))];
		if (cmd.finish && 32'(fc_q) < MAX_VERTICES) fin_mem[VW'(fc_q)] <= cur_v_q;
		if (cmd.fin_rd) fin_rd_q <= fin_mem[ptr_q];
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			r_q  <= '0;
			fc_q <= '0;
		end else begin
			if (cmd.r_inc) r_q <= r_q + SW'(1);
			if (cmd.finish && 32'(fc_q) < MAX_VERTICES) fc_q <= fc_q + SW'(1);
		end
		if (cmd.start_root) begin
			cur_v_q <= VW'(r_q);
			cur_e_q <= '0;
			sp_q    <= SW'(1);
		end else if (cmd.push) begin
			cur_v_q <= dst_rd_q;
			cur_e_q <= '0;
			sp_q    <= sp_q + SW'(1);
		end else if (cmd.pop_load) begin
			cur_v_q <= stack_rd_q[VW+CW-1:CW];
			cur_e_q <= stack_rd_q[CW-1:0];
		end else begin
			if (cmd.e_inc) cur_e_q <= cur_e_q + CW'(1);
			if (cmd.finish) sp_q <= sp_q - SW'(1);
		end
		if (cmd.ptr_init) begin
			ptr_q <= VW'(fc_q - SW'(1));
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - VW'(1);
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data.status <= cmd.out_status;
			if (cmd.out_vertex) begin
				out_data.vertex      <= 7'(fin_rd_q) + 7'd1;
				out_data.last_result <= (ptr_q == '0);
			end else begin
				out_data.vertex      <= 7'd0;
				out_data.last_result <= 1'b1;
			end
		end
	end

	assign sts.cnt_err    = (32'(edge_count_q) > MAX_EDGES) ||
		(32'(edge_count_q) > 32'(limit));
	assign sts.vtx_err    = bad_q || (32'(n_q) > MAX_VERTICES);
	assign sts.root_done  = (32'(r_q) == 32'(n_q));
	assign sts.root_white = (col_rd_q == COL_WHITE);
	assign sts.edge_end   = (cur_e_q >= edge_count_q);
	assign sts.src_match  = (src_rd_q == cur_v_q);
	assign sts.tgt_out    = (32'(dst_rd_q) >= 32'(n_q));
	assign sts.tgt_grey   = (col_rd_q == COL_GREY);
	assign sts.tgt_white  = (col_rd_q == COL_WHITE);
	assign sts.stack_full = (32'(sp_q) >= MAX_VERTICES);
	assign sts.sp_one     = (sp_q == SW'(1));
	assign sts.fc_zero    = (fc_q == '0);
	assign sts.ptr_zero   = (ptr_q == '0);
	assign sts.out_taken  = out_valid && out_ready;

endmodule

>>> bench/tb_dts_scoreboard.sv
// ----------------------------------------------------------------------------
// tb_dts_scoreboard
// Predicts the result words of each graph, sorted vertices or a status word, and checks them.
// ----------------------------------------------------------------------------
package tb_dts_sb_pkg;
	import dts_pkg::*;

	localparam int MAXV = 64;
	localparam int MAXE = 4096;

	class dts_scoreboard;
		int unsigned n_vtx;
		logic [5:0]  src_mem[MAXE];
		logic [5:0]  dst_mem[MAXE];
		int unsigned n_edges;
		bit          vtx_bad;
		out_word_t   pending[$];
		int unsigned errors;

		function new();
			n_vtx = 0;
			n_edges = 0;
			vtx_bad = 0;
			errors = 0;
		endfunction

		function void set_vertices(int unsigned n);
			n_vtx = n;
		endfunction

		function void push_status(status_t st);
			out_word_t w;
			w.vertex = '0;
			w.status = st;
			w.last_result = 1'b1;
			pending = {pending, w};
		endfunction

		// returns 1 on a cycle, fills the finish order otherwise
		function bit run_walk(output int unsigned fin[$]);
			logic [1:0]  color[MAXV];
			int unsigned stk_v[MAXV];
			int unsigned stk_e[MAXV];
			int unsigned sp, v, e, t, ne;
			fin = {};
			ne = (n_edges < MAXE) ? n_edges : MAXE;
			for (int i = 0; i < MAXV; i++) color[i] = COL_WHITE;
			for (int unsigned r = 0; r < n_vtx; r++) begin
				if (color[r] != COL_WHITE) continue;
				color[r] = COL_GREY;
				stk_v[0] = r;
				stk_e[0] = 0;
				sp = 1;
				while (sp > 0) begin
					v = stk_v[sp-1];
					e = stk_e[sp-1];
					while (e < ne && src_mem[e] != v) e++;
					if (e < ne) begin
						t = dst_mem[e];
						stk_e[sp-1] = e + 1;
						if (t >= n_vtx) continue;
						if (color[t] == COL_GREY) return 1;
						if (color[t] == COL_WHITE && sp < MAXV) begin
							color[t] = COL_GREY;
							stk_v[sp] = t;
							stk_e[sp] = 0;
							sp++;
						end
					end else begin
						sp--;
						color[v] = COL_BLACK;
						if (fin.size() < MAXV) fin = {fin, v};
					end
				end
			end
			return 0;
		endfunction

		function void note_edge_word(in_word_t w);
			int unsigned fin[$];
			int unsigned lim;
			out_word_t o;
			if (w.edge_valid) begin
				if (w.edge_from < 1 || w.edge_from > n_vtx || w.edge_from > MAXV ||
				    w.edge_to < 1 || w.edge_to > n_vtx || w.edge_to > MAXV)
					vtx_bad = 1;
				else if (n_edges < MAXE) begin
					src_mem[n_edges] = 6'(w.edge_from - 10'd1);
					dst_mem[n_edges] = 6'(w.edge_to - 10'd1);
				end
				if (n_edges <= MAXE) n_edges++;
			end
			if (!w.last) return;
			lim = n_vtx * (n_vtx + 1) / 2;
			if (n_edges > MAXE || n_edges > lim) push_status(ST_BAD_COUNT);
			else if (vtx_bad || n_vtx > MAXV) push_status(ST_BAD_VERTEX);
			else if (run_walk(fin)) push_status(ST_CYCLE);
			else if (fin.size() == 0) push_status(ST_OK);
			else begin
				for (int k = fin.size() - 1; k >= 0; k--) begin
					o.vertex = 7'(fin[k] + 1);
					o.status = ST_OK;
					o.last_result = (k == 0);
					pending = {pending, o};
				end
			end
			n_edges = 0;
			vtx_bad = 0;
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_w;
			if (pending.size() == 0) begin
				$error("unexpected result word vertex=%0d status=%0d", got.vertex, got.status);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.vertex !== exp_w.vertex) begin
				$error("vertex: expected %0d, got %0d", exp_w.vertex, got.vertex);
				errors++;
			end
			if (got.status !== exp_w.status) begin
				$error("status: expected %0d, got %0d", exp_w.status, got.status);
				errors++;
			end
			if (got.last_result !== exp_w.last_result) begin
				$error("last_result: expected %0d, got %0d", exp_w.last_result,
					got.last_result);
				errors++;
			end
		endfunction
	endclass
endpackage

>>> bench/tb_dfs_topological_sort.sv
// ----------------------------------------------------------------------------
// tb_dfs_topological_sort
// Random and directed graphs through the sorter, checked word by word.
// ----------------------------------------------------------------------------
module tb_dfs_topological_sort;
	import dts_pkg::*;
	import tb_dts_sb_pkg::*;

	localparam int WATCH_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dts_cfg_if cfg_ch();
	dts_in_if  edge_ch();
	dts_out_if res_ch();

	dfs_topological_sort dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.edge_in(edge_ch),
		.result_out(res_ch)
	);

	always #1 clk = ~clk;

	dts_scoreboard sb = new();
	int unsigned   idle_pct = 26;
	int unsigned   quiet_cycles = 0;

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		edge_ch.valid = 1'b0;
		edge_ch.data = '0;
		res_ch.ready = 1'b0;
	end

	// result side: random stall, check on accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
			res_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCH_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_vertices(int unsigned n);
		// an edge word may still be held after its accept
		edge_ch.valid <= 1'b0;
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= n[6:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.set_vertices(n);
	endtask

	task automatic send_word(logic [9:0] from, logic [9:0] to, logic ev, logic lst);
		in_word_t w;
		w.edge_from = from;
		w.edge_to = to;
		w.edge_valid = ev;
		w.last = lst;
		while ($urandom_range(99) < idle_pct) begin
			edge_ch.valid <= 1'b0;
			@(posedge clk);
		end
		edge_ch.valid <= 1'b1;
		edge_ch.data <= w;
		do @(posedge clk); while (!edge_ch.ready);
		sb.note_edge_word(w);
		// drop valid unless the next word is driven in this same step
		if (lst) edge_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// forward edges only (lower to higher index) give an acyclic graph; allow_back lets edges run both ways
	task automatic send_dag(int unsigned n, int unsigned ne, bit allow_back);
		int unsigned a, b;
		for (int unsigned i = 0; i < ne; i++) begin
			a = $urandom_range(n, 1);
			b = $urandom_range(n, 1);
			if (!allow_back && a > b) begin
				int unsigned t2;
				t2 = a; a = b; b = t2;
			end
			if (!allow_back && a == b) b = (a < n) ? a + 1 : a;
			if (!allow_back && a == b) begin
				send_word('0, '0, 1'b0, 1'b0);
				continue;
			end
			send_word(10'(a), 10'(b), 1'b1, 1'b0);
		end
		send_word('0, '0, 1'b0, 1'b1);
	endtask

	initial begin
		int unsigned n, ne;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty graph with n of zero
		write_vertices(0);
		send_word('0, '0, 1'b0, 1'b1);
		drain();
		write_vertices(4);
		send_word(10'd1, 10'd2, 1'b1, 1'b0);
		send_word(10'd2, 10'd3, 1'b1, 1'b0);
		send_word(10'd1, 10'd4, 1'b1, 1'b0);
		send_word('0, '0, 1'b0, 1'b0);
		send_word(10'd4, 10'd3, 1'b1, 1'b1);
		drain();
		// cycle
		send_word(10'd1, 10'd2, 1'b1, 1'b0);
		send_word(10'd2, 10'd1, 1'b1, 1'b1);
		drain();
		// bad vertex: zero and all ones
		send_word(10'd0, 10'd1, 1'b1, 1'b0);
		send_word(10'h3ff, 10'h3ff, 1'b1, 1'b1);
		drain();
		// bad count wins over bad vertex
		write_vertices(1);
		send_word(10'd1, 10'd1, 1'b1, 1'b0);
		send_word(10'd5, 10'd1, 1'b1, 1'b1);
		drain();
		// n above the vertex limit
		write_vertices(127);
		send_word(10'd1, 10'd2, 1'b1, 1'b1);
		drain();
		// register changed mid-graph
		write_vertices(5);
		send_word(10'd1, 10'd5, 1'b1, 1'b0);
		send_word(10'd2, 10'd1, 1'b1, 1'b0);
		write_vertices(3);
		send_word('0, '0, 1'b0, 1'b1);
		drain();
		// largest graph
		write_vertices(64);
		send_dag(64, 20, 0);
		drain();

		// random part, first stretch without idling
		idle_pct = 0;
		for (int g = 0; g < 25; g++) begin
			if (g == 4) idle_pct = 26;
			case ($urandom_range(9))
				0: n = 64;
				1: n = $urandom_range(127, 65);
				default: n = $urandom_range(8, 1);
			endcase
			write_vertices(n);
			ne = $urandom_range(7);
			if ($urandom_range(9) < 6) send_dag((n > 64) ? 8 : n, ne, 0);
			else if ($urandom_range(1)) send_dag((n > 64) ? 8 : n, ne, 1);
			else begin
				for (int unsigned i = 0; i < ne; i++)
					send_word(10'($urandom_range(1023)), 10'($urandom_range(1023)),
						1'($urandom_range(1)), 1'b0);
				send_word(10'($urandom_range(1023)), 10'($urandom_range(1023)),
					1'($urandom_range(1)), 1'b1);
			end
			drain();
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

>>> files.f
sv/dts_pkg.sv
sv/dts_if.sv
sv/dts_ctrl.sv
sv/dts_dp.sv
sv/dfs_topological_sort.sv
bench/tb_dts_scoreboard.sv
bench/tb_dfs_topological_sort.sv
